@@ hdl/ltsch_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lottery task scheduler package
// Shared constants, request and result types, controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package ltsch_pkg;

    localparam int TASK_SLOTS_DEF   = 16;
    localparam int RANDOM_RANGE_DEF = 32768;
    localparam int PRIO_MAX         = 100;
    localparam int PRIO_MIN         = 0;
    localparam int RAND_W           = 16;
    localparam int PRIO_W           = 7;

    localparam logic [1:0] CMD_CREATE   = 2'd0;
    localparam logic [1:0] CMD_DELETE   = 2'd1;
    localparam logic [1:0] CMD_SCHEDULE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_KEPT = 2'd2;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [3:0]               slot_index;
        logic signed [15:0]       priority_request;
        logic [RAND_W-1:0]        random_value;
    } t_ltsch_req;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] created_slot;
        logic [3:0] active_slot;
    } t_ltsch_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CREATE,
        S_DELETE,
        S_MOD,
        S_SUM,
        S_SUM_END,
        S_MUL,
        S_SCAN,
        S_SCAN_END,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mod_step;
        logic issue_sum;
        logic issue_scan;
        logic ptr_inc;
        logic ptr_clr;
        logic mul;
        logic create;
        logic delete_slot;
        logic kept;
        logic full;
    } t_ltsch_ctl;

    typedef struct packed {
        logic slot_free;
        logic ptr_last;
        logic mod_done;
        logic sum_zero;
    } t_ltsch_sts;

    // Clamps a signed request to the legal priority range.
    function automatic logic [PRIO_W-1:0] clamp_priority(input logic signed [15:0] req);
        logic [PRIO_W-1:0] res;
        if (req < 16'sd0) begin
            res = PRIO_W'(PRIO_MIN);
        end else if (req > 16'sd100) begin
            res = PRIO_W'(PRIO_MAX);
        end else begin
            res = req[PRIO_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ hdl/ltsch_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module ltsch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ltsch_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lottery scheduler controller
// Sequences create, delete and schedule requests through the datapath.
// ----------------------------------------------------------------------------
module ltsch_ctrl
    import ltsch_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_cmd,
    input  t_ltsch_sts i_sts,
    output t_ltsch_ctl o_ctl,
    output logic       o_busy,
    output logic       o_done
);

    t_state     r_state;
    t_state     n_state;
    t_ltsch_ctl ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        ctl     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    ctl.load = 1'b1;
                    case (i_cmd)
                        CMD_CREATE:   n_state = S_CREATE;
                        CMD_DELETE:   n_state = S_DELETE;
                        CMD_SCHEDULE: n_state = S_MOD;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            S_CREATE: begin
                if (i_sts.slot_free) begin
                    ctl.create = 1'b1;
                    n_state    = S_DONE;
                end else if (i_sts.ptr_last) begin
                    ctl.full = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    ctl.ptr_inc = 1'b1;
                end
            end
            S_DELETE: begin
                ctl.delete_slot = 1'b1;
                n_state         = S_DONE;
            end
            S_MOD: begin
                ctl.mod_step = 1'b1;
                if (i_sts.mod_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                ctl.issue_sum = 1'b1;
                if (i_sts.ptr_last) begin
                    n_state = S_SUM_END;
                end else begin
                    ctl.ptr_inc = 1'b1;
                end
            end
            S_SUM_END: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                ctl.mul     = 1'b1;
                ctl.ptr_clr = 1'b1;
                if (i_sts.sum_zero) begin
                    ctl.kept = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                ctl.issue_scan = 1'b1;
                if (i_sts.ptr_last) begin
                    n_state = S_SCAN_END;
                end else begin
                    ctl.ptr_inc = 1'b1;
                end
            end
            S_SCAN_END: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_ctl  = ctl;
    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("Accepted request did not make the block busy.");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy)
        else $error("Block stayed busy after its result.");

    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctl.create, ctl.delete_slot, ctl.kept, ctl.full}))
        else $error("More than one outcome commanded in one cycle.");

endmodule

@@ hdl/ltsch_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lottery scheduler datapath
// Slot table, draw reduction by reciprocal, priority sum and lottery walk.
// ----------------------------------------------------------------------------
module ltsch_dpath
    import ltsch_pkg::*;
#(
    parameter int TASK_SLOTS   = TASK_SLOTS_DEF,
    parameter int RANDOM_RANGE = RANDOM_RANGE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ltsch_req i_request,
    input  t_ltsch_ctl i_ctl,
    output t_ltsch_sts o_sts,
    output t_ltsch_res o_result
);

    localparam int SLOT_W  = $clog2(TASK_SLOTS);
    localparam int SUM_MAX = PRIO_MAX * TASK_SLOTS;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int CR_W    = $clog2(SUM_MAX * RANDOM_RANGE + 1);
    localparam int RECIP_W = 2 * RAND_W;
    localparam int QP_W    = RAND_W + RECIP_W;
    localparam int MOD_W   = 2 * RAND_W + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_W) / 64'(RANDOM_RANGE));

    t_ltsch_req                r_req;
    logic [TASK_SLOTS-1:0]     r_valid;
    logic [3:0]                r_active;
    logic [1:0]                r_status;
    logic [3:0]                r_created;
    logic [SLOT_W-1:0]         r_ptr;
    logic [SLOT_W-1:0]         r_rd_idx;
    logic                      r_rd_sum;
    logic                      r_rd_scan;
    logic [RAND_W-1:0]         r_rem;
    logic [RAND_W-1:0]         r_quo;
    logic                      r_mod_ph;
    logic [SUM_W-1:0]          r_sum;
    logic [CR_W-1:0]           r_rs;
    logic [CR_W-1:0]           r_cr;
    logic                      r_found;

    logic [PRIO_W-1:0]         rdata;
    logic                      rd_hit;
    logic [CR_W-1:0]           cr_next;
    logic [QP_W-1:0]           quo_prod;
    logic [MOD_W-1:0]          back_prod;
    logic [MOD_W-1:0]          mod_t;
    logic [MOD_W-1:0]          mod_r;
    logic [SLOT_W+3:0]         ptr_ext;
    logic [SLOT_W+3:0]         rd_idx_ext;
    logic [SLOT_W+3:0]         del_ext;
    logic                      del_ok;

    ltsch_ram #(
        .WIDTH (PRIO_W),
        .DEPTH (TASK_SLOTS)
    ) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.create),
        .i_waddr (r_ptr),
        .i_wdata (clamp_priority(r_req.priority_request)),
        .i_raddr (r_ptr),
        .o_rdata (rdata)
    );

    // Slot numbers are reported through their low four bits.
    assign ptr_ext    = {4'b0000, r_ptr};
    assign rd_idx_ext = {4'b0000, r_rd_idx};
    assign del_ext    = {{SLOT_W{1'b0}}, r_req.slot_index};
    assign del_ok     = (del_ext < (SLOT_W + 4)'(TASK_SLOTS));

    assign rd_hit  = r_valid[r_rd_idx];
    assign cr_next = r_cr + CR_W'(rdata) * CR_W'(RANDOM_RANGE);

    // Draw reduction in two steps. The reciprocal estimate of the quotient is
    // exact or one short, so a single conditional subtraction finishes it.
    assign quo_prod  = QP_W'(r_req.random_value) * QP_W'(RECIP);
    assign back_prod = MOD_W'(r_quo) * MOD_W'(RANDOM_RANGE);
    assign mod_t     = MOD_W'(r_req.random_value) - back_prod;
    assign mod_r     = (mod_t >= MOD_W'(RANDOM_RANGE)) ? mod_t - MOD_W'(RANDOM_RANGE) : mod_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_active  <= '0;
            r_rd_sum  <= 1'b0;
            r_rd_scan <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_rd_sum  <= i_ctl.issue_sum;
            r_rd_scan <= i_ctl.issue_scan;
            if (i_ctl.load) begin
                r_found <= 1'b0;
            end
            if (i_ctl.create) begin
                r_valid[r_ptr] <= 1'b1;
            end
            if (i_ctl.delete_slot && del_ok) begin
                r_valid[del_ext[SLOT_W-1:0]] <= 1'b0;
            end
            if (r_rd_scan && rd_hit && !r_found && (cr_next >= r_rs)) begin
                r_found  <= 1'b1;
                r_active <= rd_idx_ext[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_ptr;
        if (i_ctl.load) begin
            r_req     <= i_request;
            r_status  <= ST_OK;
            r_created <= '0;
            r_ptr     <= '0;
            r_rem     <= '0;
            r_mod_ph  <= 1'b0;
            r_sum     <= '0;
            r_cr      <= '0;
        end else begin
            if (i_ctl.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_ctl.ptr_inc) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_ctl.mod_step) begin
                if (!r_mod_ph) begin
                    r_quo <= quo_prod[QP_W-1:RECIP_W];
                end else begin
                    r_rem <= mod_r[RAND_W-1:0];
                end
                r_mod_ph <= 1'b1;
            end
            if (r_rd_sum && rd_hit) begin
                r_sum <= r_sum + SUM_W'(rdata);
            end
            if (i_ctl.mul) begin
                r_rs <= CR_W'(r_rem) * CR_W'(r_sum);
            end
            if (r_rd_scan && rd_hit && !r_found) begin
                r_cr <= cr_next;
            end
            if (i_ctl.create) begin
                r_created <= ptr_ext[3:0];
            end
            if (i_ctl.full) begin
                r_status <= ST_FULL;
            end
            if (i_ctl.kept) begin
                r_status <= ST_KEPT;
            end
        end
    end

    assign o_sts.slot_free = !r_valid[r_ptr];
    assign o_sts.ptr_last  = (r_ptr == SLOT_W'(TASK_SLOTS - 1));
    assign o_sts.mod_done  = r_mod_ph;
    assign o_sts.sum_zero  = (r_sum == '0);

    assign o_result.status       = r_status;
    assign o_result.created_slot = r_created;
    assign o_result.active_slot  = r_active;

    a_create_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.create |-> !r_valid[r_ptr])
        else $error("Create claimed a slot that is already in use.");

    a_kept_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.kept |-> (r_sum == '0))
        else $error("Previous task kept although the priority sum is nonzero.");

    a_found_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_found) |-> $past(r_rd_scan))
        else $error("Winner marked outside the lottery walk.");

endmodule

@@ hdl/lottery_task_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lottery task scheduler
// Task slot table with create, delete and weighted lottery scheduling.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low;
// busy then stays high until the result has been shown. The result appears on
// o_result for exactly one cycle, marked by o_done, and the receiver cannot
// hold it off, so it must capture it in that cycle. The next request can be
// taken in the cycle after o_done. A delete passes through its own state to
// the done state, and an unused command goes there directly. A create walks
// the valid bits one slot per cycle until it finds a free slot or, when the
// table is full, reaches the last one. A schedule first reduces the draw
// modulo RANDOM_RANGE by a reciprocal multiplication and one correcting
// subtraction; then one read of the single priority memory port per slot
// forms the total priority, the S_SUM_END state collects the last read,
// S_MUL forms the threshold product, and a second pass over the memory,
// again with the S_SCAN_END state for the last read, accumulates the
// running sum and picks the first slot that reaches the threshold. The
// running-sum test is exact integer arithmetic. If the total priority is zero
// the active task is left as it was and the result reports that. Deleting the
// active slot does not change the active task until the next schedule.
// Priorities need no clearing after reset, since they are only used for
// slots that a create has written.
// ----------------------------------------------------------------------------
module lottery_task_scheduler
    import ltsch_pkg::*;
#(
    parameter int TASK_SLOTS   = TASK_SLOTS_DEF,
    parameter int RANDOM_RANGE = RANDOM_RANGE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_ltsch_req i_request,
    output logic       busy,
    output logic       o_done,
    output t_ltsch_res o_result
);

    // Commands from the controller and status back from the datapath.
    t_ltsch_ctl ctl;
    t_ltsch_sts sts;

    // The controller decodes the command straight from the request port in
    // the accepting cycle; the datapath captures the whole request then.
    ltsch_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_request.cmd),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // The datapath holds the slot table, the active task and the result
    // registers, which stay stable while the controller shows them.
    ltsch_dpath #(
        .TASK_SLOTS   (TASK_SLOTS),
        .RANDOM_RANGE (RANDOM_RANGE)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_request (i_request),
        .i_ctl     (ctl),
        .o_sts     (sts),
        .o_result  (o_result)
    );

endmodule
